// File: rtl/lr_pkg.sv
// line rasterizer package: grid constants, datapath types and coordinate clamp
package lr_pkg;

	localparam int GRID_SIZE = 64;
	localparam int COORD_W   = 7;
	localparam int GLYPH_W   = 8;
	localparam int CNT_W     = $clog2(GRID_SIZE);
	localparam int ERR_W     = CNT_W + 3;

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [CNT_W-1:0]   dist_t;

	// per-line constants set up once per item
	typedef struct packed {
		dist_t                    a;
		logic signed [ERR_W-1:0]  b2;
		logic signed [ERR_W-1:0]  db2;
		logic                     col_major;
		logic                     col_neg;
		logic                     row_neg;
	} lr_line_t;

	// walking state of the error-term unit
	typedef struct packed {
		coord_t                   col;
		coord_t                   row;
		logic signed [ERR_W-1:0]  err;
		dist_t                    cnt;
	} lr_step_t;

	function automatic coord_t clamp_coord(input coord_t v);
		coord_t c;
		c = v;
		if (c == coord_t'(0))
			c = coord_t'(1);
		else if (c > coord_t'(GRID_SIZE))
			c = coord_t'(GRID_SIZE);
		return c;
	endfunction

endpackage

// File: rtl/line_rasterizer_top.sv
// line rasterizer top level: command intake, setup, pixel sequencer and output register
// a taken command is registered, set up into line_q and step_q, then walked to the output
// throughput: one pixel per cycle from the step unit while the output is not stalled
// a command is taken only when the previous one has been fully walked
// output stalls hold the walk; the next command may be taken while the last pixel waits
// reset (arst_n low, asynchronous) returns the sequencer to idle and empties the output
module line_rasterizer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // start_col, start_row, end_col, end_row, glyph, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // pixel_col, pixel_row, pixel_glyph, zero pad
	output logic        m_tlast   // last_pixel
);
	import lr_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	logic [1:0] state_q;
	coord_t     c1_q, r1_q, c2_q, r2_q;
	logic [GLYPH_W-1:0] glyph_q;
	lr_line_t   line_q, line_d;
	lr_step_t   step_q, step_d, step_nxt;
	logic       step_last;
	logic       out_valid_q;
	coord_t     out_col_q, out_row_q;
	logic [GLYPH_W-1:0] out_glyph_q;
	logic       out_last_q;
	logic       load;

	dist_t  ac, ar, a_sel, b_sel;
	coord_t c_lo, r_lo;
	logic   vert, horz;

	assign s_tready = (state_q == ST_IDLE);
	assign load     = (state_q == ST_RUN) && (!out_valid_q || m_tready);

	assign ac   = (c2_q >= c1_q) ? dist_t'(c2_q - c1_q) : dist_t'(c1_q - c2_q);
	assign ar   = (r2_q >= r1_q) ? dist_t'(r2_q - r1_q) : dist_t'(r1_q - r2_q);
	assign c_lo = (c1_q < c2_q) ? c1_q : c2_q;
	assign r_lo = (r1_q < r2_q) ? r1_q : r2_q;
	assign vert = (c1_q == c2_q);
	assign horz = (r1_q == r2_q);

	// straight lines reuse the stepper with zero minor distance, walking upward
	always_comb begin
		step_d.col = c1_q;
		step_d.row = r1_q;
		step_d.cnt = '0;
		line_d.col_neg   = (c2_q < c1_q);
		line_d.row_neg   = (r2_q < r1_q);
		line_d.col_major = (ac >= ar);
		priority if (vert) begin
			step_d.row = r_lo;
			line_d.row_neg   = 1'b0;
			line_d.col_major = 1'b0;
			a_sel = ar;
			b_sel = '0;
		end else if (horz) begin
			step_d.col = c_lo;
			line_d.col_neg   = 1'b0;
			line_d.col_major = 1'b1;
			a_sel = ac;
			b_sel = '0;
		end else begin
			a_sel = (ac >= ar) ? ac : ar;
			b_sel = (ac >= ar) ? ar : ac;
		end
		line_d.a   = a_sel;
		line_d.b2  = $signed(ERR_W'({b_sel, 1'b0}));
		line_d.db2 = $signed(ERR_W'({b_sel, 1'b0})) - $signed(ERR_W'({a_sel, 1'b0}));
		step_d.err = $signed(ERR_W'({b_sel, 1'b0})) - $signed(ERR_W'(a_sel));
	end

	lr_step_unit u_step (
		.cfg  (line_q),
		.cur  (step_q),
		.nxt  (step_nxt),
		.last (step_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) state_q <= ST_SETUP;
				end
				ST_SETUP: state_q <= ST_RUN;
				ST_RUN: begin
					if (load && step_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			c1_q    <= clamp_coord(s_tdata[6:0]);
			r1_q    <= clamp_coord(s_tdata[13:7]);
			c2_q    <= clamp_coord(s_tdata[20:14]);
			r2_q    <= clamp_coord(s_tdata[27:21]);
			glyph_q <= s_tdata[35:28];
		end
		if (state_q == ST_SETUP) begin
			line_q <= line_d;
			step_q <= step_d;
		end else if (load) begin
			step_q <= step_nxt;
		end
		if (load) begin
			out_col_q   <= step_q.col;
			out_row_q   <= step_q.row;
			out_glyph_q <= glyph_q;
			out_last_q  <= step_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_glyph_q, out_row_q, out_col_q};
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (step_q.cnt <= line_q.a))
		else $error("pixel count ran past line length");

	a_take_setup: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == ST_SETUP))
		else $error("accepted command did not enter setup");

	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[6:0] != 7'd0 && m_tdata[6:0] <= 7'(GRID_SIZE)
			&& m_tdata[13:7] != 7'd0 && m_tdata[13:7] <= 7'(GRID_SIZE)))
		else $error("pixel outside grid");
`endif

endmodule

// File: rtl/lr_step_unit.sv
// shared error-term step unit: one pixel advance per use
module lr_step_unit (
	input  lr_pkg::lr_line_t cfg,
	input  lr_pkg::lr_step_t cur,
	output lr_pkg::lr_step_t nxt,
	output logic             last
);
	import lr_pkg::*;

	logic   gt;
	coord_t col_step;
	coord_t row_step;

	assign gt       = cur.err > $signed(ERR_W'(0));
	assign col_step = cfg.col_neg ? cur.col - coord_t'(1) : cur.col + coord_t'(1);
	assign row_step = cfg.row_neg ? cur.row - coord_t'(1) : cur.row + coord_t'(1);
	assign last     = (cur.cnt == cfg.a);

	always_comb begin
		nxt.cnt = cur.cnt + dist_t'(1);
		// one add: error either gains 2b or gains 2b - 2a
		nxt.err = gt ? cur.err + cfg.db2 : cur.err + cfg.b2;
		if (cfg.col_major) begin
			nxt.col = col_step;
			nxt.row = gt ? row_step : cur.row;
		end else begin
			nxt.row = row_step;
			nxt.col = gt ? col_step : cur.col;
		end
	end

endmodule
